>>> rtl/pbas_pkg.sv
package pbas_pkg;

  localparam int MAX_ENTRIES  = 4096;
  localparam int MAX_BITS     = 16;
  localparam int WORD_BITS    = 64;
  localparam int MIN_PER_WORD = WORD_BITS / MAX_BITS;
  localparam int STORE_WORDS  = (MAX_ENTRIES + MIN_PER_WORD - 1) / MIN_PER_WORD;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 12;
  localparam int VAL_W    = 16;
  localparam int STAT_W   = 2;
  localparam int BITS_W   = 5;
  localparam int CNT_W    = 13;
  localparam int CFG_IDX_W = 1;
  localparam int ADDR_W   = $clog2(STORE_WORDS);
  localparam int SHIFT_W  = $clog2(WORD_BITS);
  localparam int PW_W     = SHIFT_W + 1;

  // Reciprocal divide: addr = (idx * RECIP) >> RECIP_SHIFT, exact for 12-bit idx
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = IDX_W + RECIP_W;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWAP  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_MASK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'd1;

  localparam logic [BITS_W-1:0] BITS_RESET  = 5'd4;
  localparam logic [CNT_W-1:0]  COUNT_RESET = CNT_W'(MAX_ENTRIES);

  typedef struct packed {
    logic ready;   // input side may take a request
    logic load;    // capture request and check it
    logic div;     // word address by reciprocal multiply
    logic rem;     // offset within word
    logic rd;      // bit position, memory read
    logic finish;  // merge, write back, load result register
    logic clear;   // clearing pass, one word per cycle
  } pbas_cmd_t;

  typedef struct packed {
    logic err;       // captured request is refused
    logic clr_last;  // clearing pass at last word
    logic out_free;  // result register can take a new result
  } pbas_sts_t;

  function automatic logic [PW_W-1:0] per_word_of(input logic [BITS_W-1:0] b);
    logic [PW_W-1:0] pw;
    case (b)
      5'd1:    pw = 7'd64;
      5'd2:    pw = 7'd32;
      5'd3:    pw = 7'd21;
      5'd4:    pw = 7'd16;
      5'd5:    pw = 7'd12;
      5'd6:    pw = 7'd10;
      5'd7:    pw = 7'd9;
      5'd8:    pw = 7'd8;
      5'd9:    pw = 7'd7;
      5'd10:   pw = 7'd6;
      5'd11:   pw = 7'd5;
      5'd12:   pw = 7'd5;
      default: pw = 7'd4;
    endcase
    return pw;
  endfunction

  // ceil(2^RECIP_SHIFT / per_word)
  function automatic logic [RECIP_W-1:0] recip_of(input logic [BITS_W-1:0] b);
    logic [RECIP_W-1:0] r;
    case (b)
      5'd1:    r = 18'd8192;
      5'd2:    r = 18'd16384;
      5'd3:    r = 18'd24967;
      5'd4:    r = 18'd32768;
      5'd5:    r = 18'd43691;
      5'd6:    r = 18'd52429;
      5'd7:    r = 18'd58255;
      5'd8:    r = 18'd65536;
      5'd9:    r = 18'd74899;
      5'd10:   r = 18'd87382;
      5'd11:   r = 18'd104858;
      5'd12:   r = 18'd104858;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pbas_if.sv
interface pbas_req_if;
  import pbas_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W-1:0]   entry_index;
  logic [VAL_W-1:0]   new_value;

  modport source (output valid, operation, entry_index, new_value, input ready);
  modport sink   (input valid, operation, entry_index, new_value, output ready);
endinterface

interface pbas_rsp_if;
  import pbas_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   old_value;
  logic [STAT_W-1:0]  status;

  modport source (output valid, old_value, status, input ready);
  modport sink   (input valid, old_value, status, output ready);
endinterface

>>> rtl/pbas_ram.sv
module pbas_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pbas_ctrl.sv
module pbas_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  pbas_pkg::pbas_sts_t sts_i,
  output pbas_pkg::pbas_cmd_t cmd_o
);
  import pbas_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_REM   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_MOD   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd_o.ready = 1'b1;
        cmd_o.load  = req_valid_i;
        if (req_valid_i) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        // refused requests skip the memory access
        state_d = sts_i.err ? S_MOD : S_REM;
      end
      S_REM: begin
        cmd_o.rem = 1'b1;
        state_d   = S_RD;
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_MOD;
      end
      S_MOD: begin
        cmd_o.finish = sts_i.out_free;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/pbas_dp.sv
module pbas_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pbas_pkg::pbas_cmd_t               cmd_i,
  output pbas_pkg::pbas_sts_t               sts_o,
  input  logic                              cfg_we_i,
  input  logic [pbas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pbas_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic [pbas_pkg::OP_W-1:0]         operation_i,
  input  logic [pbas_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [pbas_pkg::VAL_W-1:0]        new_value_i,
  input  logic                              rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic [pbas_pkg::VAL_W-1:0]        old_value_o,
  output logic [pbas_pkg::STAT_W-1:0]       status_o
);
  import pbas_pkg::*;

  logic [BITS_W-1:0]    bits_q;
  logic [CNT_W-1:0]     count_q;
  logic [BITS_W-1:0]    eff_bits;
  logic [CNT_W-1:0]     eff_count;
  logic [PW_W-1:0]      per_word;
  logic [RECIP_W-1:0]   recip;
  logic [VAL_W-1:0]     mask;

  logic                 writes_q;
  logic [IDX_W-1:0]     idx_q;
  logic [VAL_W-1:0]     val_q;
  logic [STAT_W-1:0]    err_q, err_d;
  logic [ADDR_W-1:0]    addr_q;
  logic [SHIFT_W-1:0]   off_q;
  logic [SHIFT_W-1:0]   shift_q;
  logic [ADDR_W-1:0]    clr_q;

  logic [PROD_W-1:0]           quot_prod;
  logic [ADDR_W+PW_W-1:0]      base_prod;
  logic [IDX_W-1:0]            off_diff;
  logic [SHIFT_W+BITS_W-1:0]   shift_prod;
  logic                        in_writes;

  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] old_word;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_waddr;
  logic                 ram_we;

  logic                 out_valid_q;
  logic [VAL_W-1:0]     old_q;
  logic [STAT_W-1:0]    status_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q  <= BITS_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENTRY_BITS:  bits_q  <= cfg_wdata_i[BITS_W-1:0];
        CFG_ENTRY_COUNT: count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bits_q == '0) begin
      eff_bits = BITS_W'(1);
    end else if (bits_q > BITS_W'(MAX_BITS)) begin
      eff_bits = BITS_W'(MAX_BITS);
    end else begin
      eff_bits = bits_q;
    end
    eff_count = (count_q > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count_q;
  end

  assign per_word = per_word_of(eff_bits);
  assign recip    = recip_of(eff_bits);
  assign mask     = ~({VAL_W{1'b1}} << eff_bits);

  // request check at capture
  assign in_writes = (operation_i == OP_WRITE) || (operation_i == OP_SWAP);

  always_comb begin
    err_d = ST_OK;
    if ({1'b0, entry_index_i} >= eff_count) begin
      err_d = ST_RANGE;
    end else if (in_writes && ((new_value_i & ~mask) != '0)) begin
      err_d = ST_MASK;
    end
  end

  assign quot_prod  = PROD_W'(idx_q) * PROD_W'(recip);
  assign base_prod  = (ADDR_W+PW_W)'(addr_q) * (ADDR_W+PW_W)'(per_word);
  assign off_diff   = idx_q - base_prod[IDX_W-1:0];
  assign shift_prod = (SHIFT_W+BITS_W)'(off_q) * (SHIFT_W+BITS_W)'(eff_bits);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      writes_q <= in_writes;
      idx_q    <= entry_index_i;
      val_q    <= new_value_i;
    end
    if (cmd_i.div) begin
      addr_q <= quot_prod[RECIP_SHIFT +: ADDR_W];
    end
    if (cmd_i.rem) begin
      off_q <= off_diff[SHIFT_W-1:0];
    end
    if (cmd_i.rd) begin
      shift_q <= shift_prod[SHIFT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= ST_OK;
      clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        err_q <= err_d;
      end
      if (cmd_i.clear) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
    end
  end

  // merge the entry into its word
  assign old_word = rdata >> shift_q;
  assign new_word = (rdata & ~({{(WORD_BITS-VAL_W){1'b0}}, mask} << shift_q))
                  | ({{(WORD_BITS-VAL_W){1'b0}}, val_q & mask} << shift_q);

  assign ram_we    = cmd_i.clear || (cmd_i.finish && writes_q && (err_q == ST_OK));
  assign ram_waddr = cmd_i.clear ? clr_q : addr_q;
  assign ram_wdata = cmd_i.clear ? '0 : new_word;

  pbas_ram #(
    .Width(WORD_BITS),
    .Depth(STORE_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(addr_q),
    .rdata_o(rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      old_q    <= (err_q == ST_OK) ? (old_word[VAL_W-1:0] & mask) : '0;
      status_q <= err_q;
    end
  end

  assign sts_o.err      = (err_q != ST_OK);
  assign sts_o.clr_last = (clr_q == ADDR_W'(STORE_WORDS - 1));
  assign sts_o.out_free = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign old_value_o = old_q;
  assign status_o    = status_q;

endmodule

>>> rtl/packed_bit_array_store_core.sv
// Packed bit-array store: 4096 entries of 1 to 16 bits, packed into 1024 words
// of 64 bits with no entry crossing a word; each request reads, writes or swaps
// one entry and returns its old value and a status (ok, index out of range,
// value above the entry mask; a range error wins, and refused requests leave
// the store unchanged and return zero). After reset the block runs a clearing
// pass over the word memory, one word a cycle, and no request is taken until
// it ends (configuration writes are taken as ever). One request is in work at
// a time: an accepted request runs through capture, reciprocal multiply for
// the word address, offset, memory read with bit position, and merge and
// write-back before its result is registered and the next request can be
// taken; a refused request skips the offset and memory read steps. The
// word-address multiply, offset and bit-position steps form a chain ahead of
// the registered memory read. The result waits in an output register, so a
// new request is accepted while the previous result is still not taken; a
// request stalls in its last step only when that register is still full.
module packed_bit_array_store_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pbas_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pbas_pkg::CNT_W-1:0]     cfg_wdata_i,
  pbas_req_if.sink                       req_i,
  pbas_rsp_if.source                     rsp_o
);
  import pbas_pkg::*;

  pbas_cmd_t cmd;
  pbas_sts_t sts;

  // sequencer: clearing pass, then one request at a time
  pbas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // configuration, index divide, word memory and result register
  pbas_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .operation_i  (req_i.operation),
    .entry_index_i(req_i.entry_index),
    .new_value_i  (req_i.new_value),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .old_value_o  (rsp_o.old_value),
    .status_o     (rsp_o.status)
  );

  // take a request only between requests, never during the clearing pass
  assign req_i.ready = cmd.ready;

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(rsp_o.valid && !rsp_o.ready))
    else $error("result register overwritten");

  // no request taken while the memory is cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !req_i.ready)
    else $error("request taken during clearing pass");

  // one request in work at a time
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !req_i.ready)
    else $error("second request taken while one is in work");

  // refused requests return zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ST_OK)) |-> (rsp_o.old_value == '0))
    else $error("refused request returned nonzero value");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pbas_pkg::*;

  // Operation code that the block treats as a plain read
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  // Cycles to hold after the last result before touching configuration
  localparam int SETTLE_CYCLES = 8;
  // Drain limit at the end of the run, in cycles
  localparam int DRAIN_LIMIT = 5000;
  // Mismatches reported in full; later ones are only counted
  localparam int REPORT_LIMIT = 10;
  // Requests per random phase (three phases)
  localparam int PHASE_REQUESTS = 534;

  typedef struct packed {
    logic [VAL_W-1:0]  old_value;
    logic [STAT_W-1:0] status;
  } access_result_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  pbas_req_if req_if ();
  pbas_rsp_if rsp_if ();

  packed_bit_array_store_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow of the block: word memory image and the two registers
  logic [WORD_BITS-1:0] word_image [STORE_WORDS];
  logic [BITS_W-1:0]    shadow_entry_bits;
  logic [CNT_W-1:0]     shadow_entry_count;

  // Results owed by the block, oldest first
  access_result_t owed_results_q [$];
  access_result_t owed_head;

  // Indices touched recently, so reads and swaps hit live entries
  int unsigned recent_index_q [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Clamp the width register the way the block does: zero acts as one bit,
  // anything above the maximum acts as the maximum
  function automatic int unsigned live_entry_bits();
    if (shadow_entry_bits == '0) return 1;
    if (shadow_entry_bits > MAX_BITS) return MAX_BITS;
    return shadow_entry_bits;
  endfunction

  function automatic int unsigned live_entry_count();
    if (shadow_entry_count > MAX_ENTRIES) return MAX_ENTRIES;
    return shadow_entry_count;
  endfunction

  // Work out the result of one accepted request and update the memory image.
  // A range error wins over a value error; refused requests change nothing.
  function automatic access_result_t compute_entry_access(
      input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
      input logic [VAL_W-1:0] val);
    int unsigned          bits;
    int unsigned          per_word;
    int unsigned          addr;
    int unsigned          shift;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] word;
    logic                 writes;
    access_result_t       res;
    bits     = live_entry_bits();
    per_word = WORD_BITS / bits;
    mask     = (64'd1 << bits) - 64'd1;
    writes   = (op == OP_WRITE) || (op == OP_SWAP);
    res.old_value = '0;
    res.status    = ST_OK;
    if (idx >= live_entry_count()) begin
      res.status = ST_RANGE;
    end else if (writes && (64'(val) > mask)) begin
      res.status = ST_MASK;
    end else begin
      addr  = idx / per_word;
      shift = (idx - addr * per_word) * bits;
      if (addr >= STORE_WORDS) begin
        res.status = ST_RANGE;
      end else begin
        word = word_image[addr];
        res.old_value = VAL_W'((word >> shift) & mask);
        if (writes) begin
          word_image[addr] = (word & ~(mask << shift)) | ((64'(val) & mask) << shift);
        end
      end
    end
    return res;
  endfunction

  // Offer one request, idling first at the sender's rate, and hold it until
  // the block takes it. Valid stays high on return so that back-to-back
  // requests never lower and raise it in the same step.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.entry_index <= idx;
    req_if.new_value   <= val;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    owed_results_q.push_back(compute_entry_access(op, idx, val));
    recent_index_q.push_back(idx);
    if (recent_index_q.size() > 16) void'(recent_index_q.pop_front());
  endtask

  // Drop valid and hold off until every owed result is back, then let the
  // block finish any trailing work before the next configuration change
  task automatic wait_store_idle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (owed_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the shadow takes it at the same edge as the block
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CNT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == CFG_ENTRY_BITS) shadow_entry_bits = data[BITS_W-1:0];
    else shadow_entry_count = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a new packing and size, mostly legal, now and then out of range
  task automatic reconfigure_random();
    int unsigned pick;
    logic [CNT_W-1:0] bits_val;
    logic [CNT_W-1:0] count_val;
    wait_store_idle();
    pick = $urandom_range(99);
    if (pick < 70) bits_val = CNT_W'($urandom_range(1, MAX_BITS));
    else if (pick < 80) bits_val = '0;
    else bits_val = CNT_W'($urandom_range(MAX_BITS + 1, 31));
    pick = $urandom_range(99);
    if (pick < 50) count_val = CNT_W'(MAX_ENTRIES);
    else if (pick < 80) count_val = CNT_W'($urandom_range(1, MAX_ENTRIES));
    else if (pick < 90) count_val = CNT_W'($urandom_range(MAX_ENTRIES + 1, 8191));
    else if (pick < 95) count_val = '0;
    else count_val = CNT_W'(1);
    write_register(CFG_ENTRY_BITS, bits_val);
    write_register(CFG_ENTRY_COUNT, count_val);
  endtask

  // Check each result the block hands over against the oldest owed one,
  // and drive ready at the receiver's idle rate
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (owed_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: old_value %h status %0d",
                   rsp_if.old_value, rsp_if.status);
      end else begin
        owed_head = owed_results_q.pop_front();
        if (rsp_if.old_value !== owed_head.old_value || rsp_if.status !== owed_head.status) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("result mismatch: old_value exp %h got %h, status exp %0d got %0d",
                     owed_head.old_value, rsp_if.old_value, owed_head.status, rsp_if.status);
        end
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Store starts cleared with 4-bit entries over the full size: probe both
  // ends of the index range, each operation, the mask check and spare code
  task automatic test_cleared_store();
    send_request(OP_READ,  IDX_W'(0),    VAL_W'(0));
    send_request(OP_READ,  IDX_W'(4095), VAL_W'(0));
    send_request(OP_WRITE, IDX_W'(4095), VAL_W'(15));
    send_request(OP_SWAP,  IDX_W'(4095), VAL_W'(10));
    send_request(OP_WRITE, IDX_W'(5),    VAL_W'(16));
    // read ignores a value far above the mask
    send_request(OP_READ,  IDX_W'(4095), VAL_W'(16'hFFFF));
    send_request(OP_SPARE, IDX_W'(4095), VAL_W'(16'hFFFF));
  endtask

  // Widest and narrowest packing, plus the clamped codes zero and 31; the
  // words are kept across each change and read back under the new layout
  task automatic test_entry_width_limits();
    wait_store_idle();
    write_register(CFG_ENTRY_BITS, CNT_W'(16));
    send_request(OP_WRITE, IDX_W'(1),    VAL_W'(16'hFFFF));
    send_request(OP_READ,  IDX_W'(1023), VAL_W'(0));
    wait_store_idle();
    write_register(CFG_ENTRY_BITS, CNT_W'(0));
    send_request(OP_READ,  IDX_W'(17), VAL_W'(0));
    send_request(OP_WRITE, IDX_W'(17), VAL_W'(2));
    send_request(OP_SWAP,  IDX_W'(17), VAL_W'(0));
    wait_store_idle();
    write_register(CFG_ENTRY_BITS, CNT_W'(31));
    send_request(OP_READ,  IDX_W'(1), VAL_W'(0));
  endtask

  // Empty store, single entry and a size register above the maximum;
  // with one-bit entries a request that breaks both limits reports range
  task automatic test_entry_count_limits();
    wait_store_idle();
    write_register(CFG_ENTRY_BITS, CNT_W'(1));
    write_register(CFG_ENTRY_COUNT, CNT_W'(0));
    send_request(OP_READ,  IDX_W'(0), VAL_W'(0));
    send_request(OP_WRITE, IDX_W'(0), VAL_W'(16'hFFFF));
    wait_store_idle();
    write_register(CFG_ENTRY_COUNT, CNT_W'(1));
    send_request(OP_READ, IDX_W'(0), VAL_W'(0));
    send_request(OP_READ, IDX_W'(1), VAL_W'(0));
    wait_store_idle();
    write_register(CFG_ENTRY_COUNT, CNT_W'(8191));
    send_request(OP_WRITE, IDX_W'(4095), VAL_W'(1));
    send_request(OP_SWAP,  IDX_W'(4095), VAL_W'(0));
  endtask

  // Mostly well-formed requests within the live size and mask, biased to
  // recent indices so written entries get read and swapped back; the rest
  // is raw noise over the full field ranges. Reconfigure every so often.
  task automatic test_random_traffic(input int unsigned n_requests,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int unsigned      until_reconfig;
    int unsigned      lim;
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    send_idle_pct  = send_pct;
    recv_idle_pct  = recv_pct;
    until_reconfig = 0;
    for (int unsigned n = 0; n < n_requests; n++) begin
      if (until_reconfig == 0) begin
        reconfigure_random();
        until_reconfig = $urandom_range(60, 200);
      end
      until_reconfig--;
      lim  = live_entry_count();
      pick = $urandom_range(99);
      if (pick < 85 && lim > 0) begin
        pick = $urandom_range(99);
        if (pick < 35) op = OP_READ;
        else if (pick < 65) op = OP_WRITE;
        else if (pick < 95) op = OP_SWAP;
        else op = OP_SPARE;
        if (recent_index_q.size() != 0 && $urandom_range(1) == 1)
          idx = IDX_W'(recent_index_q[$urandom_range(recent_index_q.size() - 1)]);
        else
          idx = IDX_W'($urandom_range(lim - 1));
        if (idx >= lim) idx = IDX_W'($urandom_range(lim - 1));
        val = VAL_W'($urandom_range((1 << live_entry_bits()) - 1));
      end else begin
        op  = OP_W'($urandom_range(3));
        idx = IDX_W'($urandom());
        val = VAL_W'($urandom());
      end
      send_request(op, idx, val);
    end
  endtask

  initial begin
    int unsigned waited;
    // Hold every input at a known value from time zero
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = '0;
    req_if.entry_index = '0;
    req_if.new_value   = '0;
    rsp_if.ready       = 1'b0;
    fail_count         = 0;
    send_idle_pct      = 37;
    recv_idle_pct      = 63;
    shadow_entry_bits  = BITS_RESET;
    shadow_entry_count = COUNT_RESET;
    foreach (word_image[i]) word_image[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block sits in its clearing pass first; requests simply wait
    test_cleared_store();
    test_entry_width_limits();
    test_entry_count_limits();
    test_random_traffic(PHASE_REQUESTS, 37, 63);
    test_random_traffic(PHASE_REQUESTS, 63, 37);
    test_random_traffic(PHASE_REQUESTS, 0, 0);

    // Drain with a limit, then watch a little longer for stray results
    req_if.valid <= 1'b0;
    waited = 0;
    while (owed_results_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    fail_count += owed_results_q.size();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/pbas_pkg.sv
rtl/pbas_if.sv
rtl/pbas_ram.sv
rtl/pbas_ctrl.sv
rtl/pbas_dp.sv
rtl/packed_bit_array_store_core.sv
tb/testbench.sv
